/* hdl/btrb_pkg.sv */
// Shared types and constants for the branch trace ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package btrb_pkg;

  localparam int RING_DEPTH_DEF = 24;
  localparam int ADDR_W         = 32;
  localparam int COUNT_W        = 32;
  localparam int IN_TDATA_W     = 72;
  localparam int OUT_TDATA_W    = 104;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Command codes carried in the input tuser
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // One ring entry, source in the lowest bits
  typedef struct packed {
    logic               exception;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  target;
    logic [ADDR_W-1:0]  source;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* hdl/btrb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module btrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/btrb_recorder.sv */
// Record path: newest-entry copy, repeat match, write position and valid bits.
`timescale 1ns / 1ps
`default_nettype none
module btrb_recorder #(
  parameter int RING_DEPTH = btrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              clear,
  input  wire logic                              rec,
  input  wire logic [btrb_pkg::ADDR_W-1:0]       src,
  input  wire logic [btrb_pkg::ADDR_W-1:0]       dst,
  input  wire logic                              exc,
  output logic                                   wr_en,
  output logic      [$clog2(RING_DEPTH)-1:0]     wr_addr,
  output btrb_pkg::entry_t                       wr_data,
  output logic      [$clog2(RING_DEPTH)-1:0]     wr_pos,
  output logic      [RING_DEPTH-1:0]             slot_valid
);

  localparam int AW = $clog2(RING_DEPTH);

  btrb_pkg::entry_t newest;
  logic             newest_valid;
  logic [AW-1:0]    newest_pos;
  logic             match;
  logic [AW-1:0]    wr_pos_next;
  btrb_pkg::entry_t fresh;
  btrb_pkg::entry_t bumped;

  assign match = newest_valid && newest.source == src && newest.target == dst &&
                 newest.exception == exc && newest.count != btrb_pkg::COUNT_MAX;

  assign wr_pos_next = (wr_pos == AW'(RING_DEPTH - 1)) ? '0 : wr_pos + 1'b1;

  always_comb begin
    fresh           = '0;
    fresh.source    = src;
    fresh.target    = dst;
    fresh.exception = exc;
    fresh.count     = btrb_pkg::COUNT_W'(1);
    bumped          = newest;
    bumped.count    = newest.count + 1'b1;
  end

  assign wr_en   = rec;
  assign wr_addr = match ? newest_pos : wr_pos;
  assign wr_data = match ? bumped : fresh;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_pos       <= '0;
      slot_valid   <= '0;
      newest_valid <= 1'b0;
    end else if (rec) begin
      if (match) begin
        newest.count <= bumped.count;
      end else begin
        newest              <= fresh;
        newest_valid        <= 1'b1;
        newest_pos          <= wr_pos;
        slot_valid[wr_pos]  <= 1'b1;
        wr_pos              <= wr_pos_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/btrb_dump.sv */
// Dump sequencer: walks the ring oldest first and drives the output stream.
`timescale 1ns / 1ps
`default_nettype none
module btrb_dump #(
  parameter int RING_DEPTH = btrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [$clog2(RING_DEPTH)-1:0]         wr_pos,
  input  wire logic [RING_DEPTH-1:0]                 slot_valid,
  output logic                                       rd_en,
  output logic      [$clog2(RING_DEPTH)-1:0]         rd_addr,
  input  wire btrb_pkg::entry_t                      rd_data,
  output logic                                       busy,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [btrb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                       m_axis_tlast
);

  localparam int AW = $clog2(RING_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_LOAD, S_SEND} state_t;

  state_t        state;
  logic [AW-1:0] slot;
  logic [AW-1:0] step;
  logic          rd_valid;

  assign busy    = state != S_IDLE;
  assign rd_en   = state == S_FETCH;
  assign rd_addr = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            slot  <= wr_pos;
            step  <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_valid <= slot_valid[slot];
          state    <= S_LOAD;
        end
        S_LOAD: begin
          // An entry never written since the last clear reads as zero
          m_axis_tdata  <= rd_valid ?
                           {(btrb_pkg::OUT_TDATA_W - btrb_pkg::ENTRY_W)'(0), rd_data} : '0;
          m_axis_tlast  <= step == AW'(RING_DEPTH - 1);
          m_axis_tvalid <= 1'b1;
          state         <= S_SEND;
        end
        S_SEND: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              state <= S_IDLE;
            end else begin
              step  <= step + 1'b1;
              slot  <= (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/branch_trace_ring_buffer.sv */
// Top level of the branch trace ring buffer.
`timescale 1ns / 1ps
`default_nettype none
// Trace ring of taken branches with repeat counting. An input item with
// tuser 0 records one branch (source, target, exception flag) while tracing
// is enabled; records stream at one item per cycle while no dump is running.
// A branch equal to the newest entry, whose count is below the 32-bit
// maximum, bumps that count; otherwise it lands at the write position with
// count 1 and the position wraps. An item with tuser 1 dumps all RING_DEPTH
// entries oldest first, the newest marked by tlast; each output item takes a
// RAM read, then a load of the output register, then a handshake, and
// s_axis_tready stays low meanwhile. Entries live in one RAM with one write
// and one registered read port; per-entry valid bits in flip-flops make a
// cleared entry read as zero, so reset and a write of 0 to the enable
// register take effect at once with no clearing pass.
module branch_trace_ring_buffer #(
  parameter int RING_DEPTH = btrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration: trace_enable in bit 0
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_data,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [31:0] source_address, [63:32] target_address, [64] is_exception
  input  wire logic [btrb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [31:0] entry_source, [63:32] entry_target, [95:64] entry_count,
  // [96] entry_exception
  output logic      [btrb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // last_entry
  output logic                                      m_axis_tlast
);

  localparam int AW = $clog2(RING_DEPTH);

  logic             trace_enable;
  logic             clear;
  logic             in_take;
  logic             rec;
  logic             dump_start;
  logic             dump_busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  btrb_pkg::entry_t wr_data;
  logic [AW-1:0]    wr_pos;
  logic [RING_DEPTH-1:0] slot_valid;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  btrb_pkg::entry_t rd_data;

  // Configuration is always taken; a write of 0 wipes the ring
  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && !cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable <= 1'b0;
    end else if (cfg_valid) begin
      trace_enable <= cfg_data;
    end
  end

  // Hold off input items for the length of a dump
  assign s_axis_tready = !dump_busy;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign rec           = in_take && s_axis_tuser == btrb_pkg::CMD_RECORD && trace_enable;
  assign dump_start    = in_take && s_axis_tuser == btrb_pkg::CMD_DUMP;

  btrb_recorder #(
    .RING_DEPTH(RING_DEPTH)
  ) u_recorder (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .rec        (rec),
    .src        (s_axis_tdata[31:0]),
    .dst        (s_axis_tdata[63:32]),
    .exc        (s_axis_tdata[64]),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .wr_pos     (wr_pos),
    .slot_valid (slot_valid)
  );

  btrb_ram #(
    .WIDTH(btrb_pkg::ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  btrb_dump #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dump (
    .clk           (clk),
    .rst           (rst),
    .start         (dump_start),
    .wr_pos        (wr_pos),
    .slot_valid    (slot_valid),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (dump_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // No input is taken while a dump item is on offer
  a_no_input_during_dump: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while dump output pending");

  // A dump item blocks the input on the next cycle
  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == btrb_pkg::CMD_DUMP)
      |=> !s_axis_tready)
    else $error("dump did not start");

  // Taking the last dump item returns the block to idle
  a_last_ends_dump: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("dump did not end on last item");

  // Records never touch the RAM while a dump reads it
  a_no_write_in_dump: assert property (@(posedge clk) disable iff (rst)
    dump_busy |-> !wr_en)
    else $error("RAM write during dump");
`endif

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the branch trace ring buffer.
`timescale 1ns / 1ps
module tb;
  import btrb_pkg::*;

  localparam int DEPTH      = RING_DEPTH_DEF;
  localparam int LONG_STALL = 400;
  // Settle time covers a full dump with room to spare.
  localparam int SETTLE     = 3 * DEPTH + 40;
  localparam int QUIET      = 8;
  localparam int MAX_LINES  = 50;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              exc;
  } trace_item_t;

  typedef struct packed {
    entry_t ent;
    logic   last;
  } dump_word_t;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data      = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = CMD_RECORD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  branch_trace_ring_buffer #(.RING_DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Items waiting for the driver, and dump entries still owed by the block
  trace_item_t to_send[$];
  dump_word_t  dump_due[$];
  int unsigned mismatches = 0;

  // Pacing controls, set by the stimulus with nonblocking writes
  logic feed_lively     = 1'b0;
  logic drain_lively    = 1'b0;
  logic long_hold_armed = 1'b0;

  // Shadow copy of the ring
  entry_t      shadow[DEPTH];
  logic        shadow_valid[DEPTH];
  int unsigned next_slot;
  logic        tracing;

  function automatic int unsigned pause_len(logic lively);
    return lively ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow[i]) begin
      shadow[i]       = '0;
      shadow_valid[i] = 1'b0;
    end
    next_slot = 0;
  endfunction

  // Bump the newest entry on a repeat, else open a new entry and advance.
  function automatic void log_branch(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                     logic exc);
    int unsigned newest;
    newest = (next_slot + DEPTH - 1) % DEPTH;
    if (shadow_valid[newest] && shadow[newest].source == src &&
        shadow[newest].target == dst && shadow[newest].exception == exc &&
        shadow[newest].count < COUNT_MAX) begin
      shadow[newest].count = shadow[newest].count + 1'b1;
    end else begin
      shadow[next_slot].source    = src;
      shadow[next_slot].target    = dst;
      shadow[next_slot].exception = exc;
      shadow[next_slot].count     = COUNT_W'(1);
      shadow_valid[next_slot]     = 1'b1;
      next_slot = (next_slot + 1) % DEPTH;
    end
  endfunction

  // Oldest entry sits at the write position; the newest closes the dump.
  function automatic void queue_dump();
    dump_word_t w;
    for (int k = 0; k < DEPTH; k++) begin
      w.ent  = shadow[(k + next_slot) % DEPTH];
      w.last = (k == DEPTH - 1);
      dump_due = {dump_due, w};
    end
  endfunction

  task automatic report(string msg);
    if (mismatches < MAX_LINES) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_word(entry_t got, logic got_last);
    dump_word_t want;
    if (dump_due.size() == 0) begin
      report($sformatf("output item with nothing pending: src=%h", got.source));
      return;
    end
    want = dump_due.pop_front();
    if (got.source !== want.ent.source)
      report($sformatf("entry_source %h, want %h", got.source, want.ent.source));
    if (got.target !== want.ent.target)
      report($sformatf("entry_target %h, want %h", got.target, want.ent.target));
    if (got.count !== want.ent.count)
      report($sformatf("entry_count %h, want %h", got.count, want.ent.count));
    if (got.exception !== want.ent.exception)
      report($sformatf("entry_exception %b, want %b", got.exception, want.ent.exception));
    if (got_last !== want.last)
      report($sformatf("last_entry %b, want %b", got_last, want.last));
  endtask

  // Predict on every accepted item, then check every result
  always @(posedge clk) begin
    if (rst) begin
      clear_shadow();
      tracing = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tracing = cfg_data;
        if (!cfg_data) clear_shadow();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_DUMP) queue_dump();
        else if (tracing) log_branch(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[64]);
      end
      if (m_axis_tvalid && m_axis_tready)
        check_word(m_axis_tdata[ENTRY_W-1:0], m_axis_tlast);
    end
  end

  // Input driver: hold an item until taken, then pause for a drawn gap
  trace_item_t feed_item;
  int unsigned feed_wait;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      feed_wait = 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      ;
    end else if (feed_wait > 0) begin
      feed_wait--;
      s_axis_tvalid <= 1'b0;
    end else if (to_send.size() > 0) begin
      feed_item = to_send.pop_front();
      s_axis_tuser  <= feed_item.cmd;
      s_axis_tdata  <= {{(IN_TDATA_W - 65){1'b0}}, feed_item.exc, feed_item.dst, feed_item.src};
      s_axis_tvalid <= 1'b1;
      feed_wait = pause_len(feed_lively);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Output side: drawn stall after each item, plus one long hold-off
  int unsigned drain_wait;
  int unsigned long_stall;
  logic        long_hold_taken;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      drain_wait      = 0;
      long_stall      = 0;
      long_hold_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) drain_wait = pause_len(drain_lively);
      if (long_hold_armed && !long_hold_taken) begin
        long_stall      = LONG_STALL;
        long_hold_taken = 1'b1;
      end
      if (long_stall > 0) begin
        long_stall--;
        m_axis_tready <= 1'b0;
      end else if (drain_wait > 0) begin
        drain_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_record(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst, logic exc);
    trace_item_t it;
    it.cmd = CMD_RECORD;
    it.src = src;
    it.dst = dst;
    it.exc = exc;
    to_send = {to_send, it};
  endtask

  // Dumps carry random payload bits, which the block must ignore
  task automatic push_dump();
    trace_item_t it;
    it.cmd = CMD_DUMP;
    it.src = $urandom;
    it.dst = $urandom;
    it.exc = 1'($urandom_range(0, 1));
    to_send = {to_send, it};
  endtask

  // Wait until everything is sent and every dump entry has come back
  task automatic wait_quiet();
    do @(negedge clk);
    while (to_send.size() != 0 || s_axis_tvalid || dump_due.size() != 0);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly repeats and loops over a few hot branches, so counts climb and
  // the ring wraps; the rest is fresh branches and occasional dumps.
  task automatic random_phase(int n_items);
    trace_item_t pool[4];
    trace_item_t prev;
    logic        have_prev;
    int unsigned roll;
    foreach (pool[i]) begin
      pool[i].cmd = CMD_RECORD;
      pool[i].src = $urandom;
      pool[i].dst = $urandom;
      pool[i].exc = 1'($urandom_range(0, 1));
    end
    have_prev = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        push_dump();
      end else begin
        if (roll < 45 && have_prev) begin
          ;
        end else if (roll < 75) begin
          prev = pool[$urandom_range(0, 3)];
        end else begin
          prev.cmd = CMD_RECORD;
          prev.src = $urandom;
          prev.dst = $urandom;
          prev.exc = 1'($urandom_range(0, 1));
        end
        have_prev = 1'b1;
        push_record(prev.src, prev.dst, prev.exc);
      end
    end
    push_dump();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: dumps read all zero, a record is dropped
    push_dump();
    push_record(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    push_dump();
    wait_quiet();

    // Extremes, repeats and an exception-flag change on the same addresses
    write_enable(1'b1);
    push_record('0, '0, 1'b0);
    push_record('1, '1, 1'b1);
    push_record('1, '1, 1'b1);
    push_record('1, '1, 1'b1);
    push_record('1, '1, 1'b0);
    push_record('0, '0, 1'b0);
    push_record(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push_record(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    push_dump();
    wait_quiet();

    // Enabling again keeps the contents
    write_enable(1'b1);
    push_dump();
    wait_quiet();

    // Disabling clears the ring; dumps still run
    write_enable(1'b0);
    push_record(32'hDEAD_BEEF, 32'h0000_0004, 1'b0);
    push_dump();
    wait_quiet();
    write_enable(1'b1);

    for (int p = 0; p < 12; p++) begin
      feed_lively  <= p[0];
      drain_lively <= p[1];
      if (p == 5) begin
        long_hold_armed <= 1'b1;
        push_dump();
      end
      random_phase(30);
      wait_quiet();
      write_enable($urandom_range(0, 3) != 0);
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
